@@ design/mrfc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrfc_pkg: shared types and constants of the Modbus RTU request checker
// Holds the result status codes, the frame layout constants, the CRC-16
// constants and the function code classification used by every module.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfc_pkg;

	localparam int unsigned CNT_W  = 9;
	localparam int unsigned CRC_W  = 16;
	localparam int unsigned BYTE_W = 8;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

	localparam logic [CNT_W-1:0] CNT_MAX     = 9'd511;
	localparam logic [CNT_W-1:0] POS_ADDR    = 9'd1;
	localparam logic [CNT_W-1:0] POS_FUNC    = 9'd2;
	localparam logic [CNT_W-1:0] POS_CHECK   = 9'd5;
	localparam logic [CNT_W-1:0] POS_BCOUNT  = 9'd7;
	localparam logic [CNT_W-1:0] FIXED_LEN   = 9'd8;
	localparam logic [CNT_W-1:0] VAR_LEN_OFS = 9'd9;

	localparam logic [BYTE_W-1:0] FC_FIXED_LO = 8'h01;
	localparam logic [BYTE_W-1:0] FC_FIXED_HI = 8'h06;
	localparam logic [BYTE_W-1:0] FC_WR_COILS = 8'h0F;
	localparam logic [BYTE_W-1:0] FC_WR_REGS  = 8'h10;

	localparam logic [BYTE_W-1:0] SLAVE_ADDR_RESET = 8'd1;

	typedef enum logic [1:0] {
		ST_NOT_READY = 2'd0,
		ST_COMPLETE  = 2'd1,
		ST_BAD_ADDR  = 2'd2,
		ST_BAD_FUNC  = 2'd3
	} status_t;

	typedef struct packed {
		status_t           status;
		logic              crc_ok;
		logic [BYTE_W-1:0] function_code;
		logic [CNT_W-1:0]  frame_length;
	} result_t;

	// Read and write-single functions have a fixed eight byte request.
	function automatic logic is_fixed_func(input logic [BYTE_W-1:0] fc);
		return (fc inside {[FC_FIXED_LO:FC_FIXED_HI]});
	endfunction

	// Write-multiple functions carry their data length in byte seven.
	function automatic logic is_var_func(input logic [BYTE_W-1:0] fc);
		return (fc == FC_WR_COILS) || (fc == FC_WR_REGS);
	endfunction

endpackage

`default_nettype wire

@@ design/mrfc_crc8.sv @@
// ----------------------------------------------------------------------------
// mrfc_crc8: one-byte CRC-16/Modbus update
// Folds one byte into a running reflected CRC-16, eight shift steps unrolled.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfc_crc8 (
	input  wire logic [mrfc_pkg::CRC_W-1:0]  crc_in,
	input  wire logic [mrfc_pkg::BYTE_W-1:0] data,
	output logic      [mrfc_pkg::CRC_W-1:0]  crc_out
);

	always_comb begin
		logic [mrfc_pkg::CRC_W-1:0] c;
		c = crc_in ^ {{(mrfc_pkg::CRC_W-mrfc_pkg::BYTE_W){1'b0}}, data};
		for (int i = 0; i < mrfc_pkg::BYTE_W; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ mrfc_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

@@ design/mrfc_frame.sv @@
// ----------------------------------------------------------------------------
// mrfc_frame: frame state and classification
// Keeps the byte count, running CRC, address, function and expected length
// of the current frame, and works out the result for the byte on its input.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfc_frame (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic [mrfc_pkg::BYTE_W-1:0]  rx_byte,
	input  wire logic                         frame_start,
	input  wire logic [mrfc_pkg::BYTE_W-1:0]  slave_address,
	output mrfc_pkg::result_t                 result
);

	logic [mrfc_pkg::CNT_W-1:0]  count_q,    count_d;
	logic [mrfc_pkg::CRC_W-1:0]  crc_q,      crc_d;
	logic [mrfc_pkg::BYTE_W-1:0] func_q,     func_d;
	logic [mrfc_pkg::BYTE_W-1:0] addr_q,     addr_d;
	logic [mrfc_pkg::CNT_W-1:0]  exp_len_q,  exp_len_d;
	logic                        discard_q,  discard_d;

	logic [mrfc_pkg::CNT_W-1:0]  count0;
	logic [mrfc_pkg::CRC_W-1:0]  crc0;
	logic [mrfc_pkg::CRC_W-1:0]  crc_next;
	logic [mrfc_pkg::BYTE_W-1:0] func0;
	logic [mrfc_pkg::BYTE_W-1:0] addr0;
	logic [mrfc_pkg::CNT_W-1:0]  exp_len0;
	logic                        discard0;

	// A frame start clears the frame state before the byte is taken in.
	assign count0   = frame_start ? '0 : count_q;
	assign crc0     = frame_start ? mrfc_pkg::CRC_INIT : crc_q;
	assign func0    = frame_start ? '0 : func_q;
	assign addr0    = frame_start ? '0 : addr_q;
	assign exp_len0 = frame_start ? '0 : exp_len_q;
	assign discard0 = frame_start ? 1'b0 : discard_q;

	mrfc_crc8 u_crc (
		.crc_in  (crc0),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	always_comb begin
		logic [mrfc_pkg::CNT_W-1:0] cnt1;
		mrfc_pkg::status_t          st;

		count_d   = count0;
		crc_d     = crc0;
		func_d    = func0;
		addr_d    = addr0;
		exp_len_d = exp_len0;
		discard_d = discard0;
		cnt1      = count0;
		st        = mrfc_pkg::ST_NOT_READY;

		result.status        = mrfc_pkg::ST_NOT_READY;
		result.crc_ok        = 1'b0;
		result.function_code = func0;
		result.frame_length  = count0;

		if (!discard0) begin
			crc_d = crc_next;
			cnt1  = (count0 < mrfc_pkg::CNT_MAX) ? count0 + 1'b1 : count0;
			if (cnt1 == mrfc_pkg::POS_ADDR) begin
				addr_d = rx_byte;
			end else if (cnt1 == mrfc_pkg::POS_FUNC) begin
				func_d = rx_byte;
			end

			if (cnt1 == mrfc_pkg::POS_CHECK) begin
				if (addr_d != slave_address) begin
					st = mrfc_pkg::ST_BAD_ADDR;
				end else if (mrfc_pkg::is_fixed_func(func_d)) begin
					exp_len_d = mrfc_pkg::FIXED_LEN;
				end else if (mrfc_pkg::is_var_func(func_d)) begin
					exp_len_d = '0;
				end else begin
					st = mrfc_pkg::ST_BAD_FUNC;
				end
			end else if (cnt1 == mrfc_pkg::POS_BCOUNT && mrfc_pkg::is_var_func(func_d)) begin
				exp_len_d = {1'b0, rx_byte} + mrfc_pkg::VAR_LEN_OFS;
			end

			count_d              = cnt1;
			result.function_code = func_d;
			result.frame_length  = cnt1;

			if (st != mrfc_pkg::ST_NOT_READY) begin
				// Rejected: drop everything up to the next frame start.
				discard_d     = 1'b1;
				count_d       = '0;
				crc_d         = mrfc_pkg::CRC_INIT;
				result.status = st;
			end else if (exp_len_d != '0 && cnt1 == exp_len_d) begin
				result.status = mrfc_pkg::ST_COMPLETE;
				result.crc_ok = (crc_next == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			crc_q     <= mrfc_pkg::CRC_INIT;
			func_q    <= '0;
			addr_q    <= '0;
			exp_len_q <= '0;
			discard_q <= 1'b1;
		end else if (advance) begin
			count_q   <= count_d;
			crc_q     <= crc_d;
			func_q    <= func_d;
			addr_q    <= addr_d;
			exp_len_q <= exp_len_d;
			discard_q <= discard_d;
		end
	end

endmodule

`default_nettype wire

@@ design/modbus_rtu_request_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_request_frame_checker_top: Modbus RTU request frame checker
// Streams request bytes in, checks address, function, length and CRC-16,
// and gives one status beat out for every byte beat in.
// ----------------------------------------------------------------------------
// Each input beat carries one received byte and a frame start flag in tuser;
// each input beat produces exactly one output beat, in order. The block takes
// a beat on every clock cycle: the byte is captured in an input register, the
// CRC update and frame classification run in one pass of logic, and the
// result lands in an output register. The result of a byte is therefore
// offered only after it has passed through the input register, the frame
// logic and the output register in that order. Throughput is one beat
// per cycle as long as the output side keeps taking beats. While the output
// side stalls, the output register holds one finished result and the input
// register takes one more byte before s_tready falls; once both registers are
// full, s_tready follows m_tready combinationally. On the fifth byte of a
// frame the address is compared with the slave address register as it stands
// at that moment; a mismatch or an unknown function code is reported and the
// rest of the frame is dropped until the next frame start. Before the first
// frame start after reset all bytes are dropped. The slave address register
// resets to 1 and should only be written while no beats are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_frame_checker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: slave address register.
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	// Slave side: received bytes.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [0:0]  s_tuser,   // [0] frame_start
	// Master side: per-byte status.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] function_code, [16:8] frame_length, zero above
	output logic [2:0]       m_tuser    // [1:0] status, [2] crc_ok
);

	logic [mrfc_pkg::BYTE_W-1:0] slave_addr_q;

	logic                        valid_s1;
	logic [mrfc_pkg::BYTE_W-1:0] byte_s1;
	logic                        start_s1;

	logic                        valid_s2;
	mrfc_pkg::result_t           result_s2;

	mrfc_pkg::result_t           result;
	logic                        advance;

	// A held byte moves on when the result stage is empty or its beat is being taken.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= mrfc_pkg::SLAVE_ADDR_RESET;
		end else if (cfg_we) begin
			slave_addr_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	mrfc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.rx_byte       (byte_s1),
		.frame_start   (start_s1),
		.slave_address (slave_addr_q),
		.result        (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, result_s2.frame_length, result_s2.function_code};
	assign m_tuser  = {result_s2.crc_ok, result_s2.status};

endmodule

`default_nettype wire

@@ design/mrfc_checker.sv @@
// ----------------------------------------------------------------------------
// mrfc_checker: port-level checks of the request frame checker
// Watches the output stream and checks that reported results are consistent.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// A stalled output beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// A good CRC is only ever flagged on a complete frame.
	a_crc_ok_complete: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == mrfc_pkg::ST_COMPLETE)
		else $error("crc_ok set without a complete frame");

	// Rejections happen on the fifth byte only.
	a_reject_at_five: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == mrfc_pkg::ST_BAD_ADDR ||
		             m_tuser[1:0] == mrfc_pkg::ST_BAD_FUNC)
		|-> m_tdata[16:8] == mrfc_pkg::POS_CHECK)
		else $error("rejection reported away from the fifth byte");

	// A complete frame is at least eight bytes and has a supported function.
	a_complete_sane: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == mrfc_pkg::ST_COMPLETE
		|-> m_tdata[16:8] >= mrfc_pkg::FIXED_LEN &&
		    ((m_tdata[7:0] >= mrfc_pkg::FC_FIXED_LO && m_tdata[7:0] <= mrfc_pkg::FC_FIXED_HI) ||
		     m_tdata[7:0] == mrfc_pkg::FC_WR_COILS || m_tdata[7:0] == mrfc_pkg::FC_WR_REGS))
		else $error("complete frame with impossible length or function");

endmodule

bind modbus_rtu_request_frame_checker_top mrfc_checker u_mrfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ verif/tb_modbus_rtu_request_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// tb_modbus_rtu_request_frame_checker_top: self-checking bench for the checker
// Drives Modbus RTU request bytes into the block and predicts every status
// beat with a cycle-free model of the frame checker held in a scoreboard.
// Each output beat is compared field by field with the oldest prediction,
// under mixed idling on both sides, several slave addresses and a long
// output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modbus_rtu_request_frame_checker_top;

	// Bytes of framed traffic aimed at for each random phase.
	localparam int PHASE_BYTES = 190;

	// Length of the long output hold-off, in cycles.
	localparam int HOLD_CYCLES = 150;

	// ------------------------------------------------------------------------
	// Scoreboard: a byte-level model of the frame checker together with the
	// queue of status beats that it has predicted but not yet seen.
	// ------------------------------------------------------------------------
	class frame_status_board;
		mrfc_pkg::result_t          status_due_q[$];
		int unsigned                errors;
		int unsigned                bytes_framed;
		int unsigned                frames_complete;
		int unsigned                frames_crc_good;
		int unsigned                addr_rejects;
		int unsigned                func_rejects;
		int unsigned                beats_checked;
		logic [7:0]                 station_addr;
		logic [mrfc_pkg::CNT_W-1:0] byte_cnt;
		logic [mrfc_pkg::CRC_W-1:0] frame_crc;
		logic [7:0]                 func_seen;
		logic [7:0]                 addr_seen;
		logic [mrfc_pkg::CNT_W-1:0] due_len;
		logic                       dropping;

		function new();
			errors          = 0;
			bytes_framed    = 0;
			frames_complete = 0;
			frames_crc_good = 0;
			addr_rejects    = 0;
			func_rejects    = 0;
			beats_checked   = 0;
			station_addr    = mrfc_pkg::SLAVE_ADDR_RESET;
			byte_cnt        = '0;
			frame_crc       = mrfc_pkg::CRC_INIT;
			func_seen       = '0;
			addr_seen       = '0;
			due_len         = '0;
			dropping        = 1'b1;
		endfunction

		// One byte of CRC-16/Modbus, bit by bit, least significant bit first.
		static function logic [mrfc_pkg::CRC_W-1:0] crc16_step(
				input logic [mrfc_pkg::CRC_W-1:0] c_in, input logic [7:0] b);
			logic [mrfc_pkg::CRC_W-1:0] c;
			int                         i;
			c = c_in ^ {8'h00, b};
			for (i = 0; i < 8; i++) begin
				if (c[0]) begin
					c = (c >> 1) ^ mrfc_pkg::CRC_POLY;
				end else begin
					c = c >> 1;
				end
			end
			return c;
		endfunction

		function void set_station(input logic [7:0] a);
			station_addr = a;
		endfunction

		function automatic logic is_var_code(input logic [7:0] fc);
			return (fc == mrfc_pkg::FC_WR_COILS) || (fc == mrfc_pkg::FC_WR_REGS);
		endfunction

		// Works out the status beat caused by one accepted byte.
		function void take_byte(input logic [7:0] b, input logic start);
			mrfc_pkg::result_t          r;
			mrfc_pkg::status_t          st;
			logic                       ok;
			logic [mrfc_pkg::CNT_W-1:0] shown;
			st = mrfc_pkg::ST_NOT_READY;
			ok = 1'b0;
			if (start) begin
				byte_cnt  = '0;
				frame_crc = mrfc_pkg::CRC_INIT;
				func_seen = '0;
				addr_seen = '0;
				due_len   = '0;
				dropping  = 1'b0;
			end
			if (dropping) begin
				r.status        = mrfc_pkg::ST_NOT_READY;
				r.crc_ok        = 1'b0;
				r.function_code = func_seen;
				r.frame_length  = byte_cnt;
				status_due_q.push_back(r);
				return;
			end
			bytes_framed++;
			frame_crc = crc16_step(frame_crc, b);
			if (byte_cnt != mrfc_pkg::CNT_MAX) begin
				byte_cnt = byte_cnt + 1'b1;
			end
			if (byte_cnt == mrfc_pkg::POS_ADDR) begin
				addr_seen = b;
			end else if (byte_cnt == mrfc_pkg::POS_FUNC) begin
				func_seen = b;
			end
			if (byte_cnt == mrfc_pkg::POS_CHECK) begin
				if (addr_seen != station_addr) begin
					st = mrfc_pkg::ST_BAD_ADDR;
				end else if (func_seen >= mrfc_pkg::FC_FIXED_LO &&
						func_seen <= mrfc_pkg::FC_FIXED_HI) begin
					due_len = mrfc_pkg::FIXED_LEN;
				end else if (is_var_code(func_seen)) begin
					due_len = '0;
				end else begin
					st = mrfc_pkg::ST_BAD_FUNC;
				end
			end else if (byte_cnt == mrfc_pkg::POS_BCOUNT && is_var_code(func_seen)) begin
				due_len = {1'b0, b} + mrfc_pkg::VAR_LEN_OFS;
			end
			shown = byte_cnt;
			if (st != mrfc_pkg::ST_NOT_READY) begin
				// A rejected frame is dropped up to the next frame start.
				dropping  = 1'b1;
				byte_cnt  = '0;
				frame_crc = mrfc_pkg::CRC_INIT;
				if (st == mrfc_pkg::ST_BAD_ADDR) begin
					addr_rejects++;
				end else begin
					func_rejects++;
				end
			end else if (due_len != '0 && byte_cnt == due_len) begin
				st = mrfc_pkg::ST_COMPLETE;
				ok = (frame_crc == '0);
				frames_complete++;
				if (ok) begin
					frames_crc_good++;
				end
			end
			r.status        = st;
			r.crc_ok        = ok;
			r.function_code = func_seen;
			r.frame_length  = shown;
			status_due_q.push_back(r);
		endfunction

		task report_mismatch(input string what, input logic [31:0] got,
				input logic [31:0] want);
			if (errors < 100) begin
				$display("MISMATCH beat %0d %s: got %0h, expected %0h",
					beats_checked, what, got, want);
			end
			errors++;
		endtask

		// Compares one output beat with the oldest predicted status.
		task check_status_beat(input logic [23:0] data, input logic [2:0] flags);
			mrfc_pkg::result_t want;
			if (status_due_q.size() == 0) begin
				report_mismatch("unexpected beat", {8'h00, data}, 32'h0);
				return;
			end
			want = status_due_q.pop_front();
			if (flags[1:0] !== want.status) begin
				report_mismatch("status", flags[1:0], want.status);
			end
			if (flags[2] !== want.crc_ok) begin
				report_mismatch("crc_ok", flags[2], want.crc_ok);
			end
			if (data[7:0] !== want.function_code) begin
				report_mismatch("function_code", data[7:0], want.function_code);
			end
			if (data[16:8] !== want.frame_length) begin
				report_mismatch("frame_length", data[16:8], want.frame_length);
			end
			if (data[23:17] !== 7'd0) begin
				report_mismatch("tdata padding", data[23:17], 32'h0);
			end
			beats_checked++;
		endtask
	endclass

	// One planned input beat: the byte and its frame start flag.
	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} rx_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;

	frame_status_board sb;
	rx_beat_t          plan_q[$];

	// Idling odds in percent, and the hold-off handed to the receiver.
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_request;
	int hold_left;

	modbus_rtu_request_frame_checker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both handshakes are sampled at the rising edge, where every input has
	// been steady since the falling edge before it. An accepted input byte is
	// noted before the output beat of the same edge is checked; the output
	// can only belong to an earlier byte, so the order is harmless.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.take_byte(s_tdata, s_tuser[0]);
			end
			if (m_tvalid && m_tready) begin
				sb.check_status_beat(m_tdata, m_tuser);
			end
		end
	end

	// The receiver. A requested hold-off keeps tready low for a counted
	// number of cycles; otherwise tready follows the idling odds. Exactly one
	// assignment is made at each falling edge.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready  = 1'b0;
		end else if (hold_request != 0) begin
			hold_left    = hold_request - 1;
			hold_request = 0;
			m_tready     = 1'b0;
		end else begin
			m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	function automatic logic [7:0] pick_served_func();
		int r;
		r = $urandom_range(0, 7);
		if (r < 6) begin
			return mrfc_pkg::FC_FIXED_LO + 8'(r);
		end else if (r == 6) begin
			return mrfc_pkg::FC_WR_COILS;
		end
		return mrfc_pkg::FC_WR_REGS;
	endfunction

	task automatic add_beat(input logic [7:0] d, input logic s);
		rx_beat_t x;
		x.data  = d;
		x.start = s;
		plan_q.push_back(x);
	endtask

	// Plans one request: address, function, four header bytes, then for the
	// write-multiple codes a byte count and that many data bytes, and the CRC
	// low byte first. The frame may be corrupted in one bit, cut after `keep`
	// bytes, or followed by `extra` bytes without a frame start.
	task automatic plan_request(input logic [7:0] addr, input logic [7:0] fc,
			input int n, input bit corrupt, input int keep, input int extra);
		logic [7:0]                 body[$];
		logic [mrfc_pkg::CRC_W-1:0] c;
		int                         k;
		int                         pick;
		int                         pos;
		int                         total;
		body.push_back(addr);
		body.push_back(fc);
		repeat (4) body.push_back(8'($urandom_range(0, 255)));
		if (fc == mrfc_pkg::FC_WR_COILS || fc == mrfc_pkg::FC_WR_REGS) begin
			body.push_back(8'(n));
			repeat (n) body.push_back(8'($urandom_range(0, 255)));
		end
		c = mrfc_pkg::CRC_INIT;
		for (k = 0; k < body.size(); k++) begin
			c = frame_status_board::crc16_step(c, body[k]);
		end
		body.push_back(c[7:0]);
		body.push_back(c[15:8]);
		if (corrupt) begin
			// Flip a header or CRC bit, never the address, function or count.
			pick = $urandom_range(0, 5);
			pos  = (pick < 4) ? pick + 2 : body.size() - 6 + pick;
			body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		total = (keep != 0 && keep < body.size()) ? keep : body.size();
		for (k = 0; k < total; k++) begin
			add_beat(body[k], k == 0);
		end
		repeat (extra) add_beat(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Plans one random piece of traffic. Most of it is well formed requests
	// to this station, so that frames reach the length and CRC checks.
	task automatic plan_random_traffic();
		int         kind;
		int         n;
		logic [7:0] a;
		logic [7:0] f;
		kind = $urandom_range(0, 99);
		n    = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
		a    = sb.station_addr;
		f    = pick_served_func();
		if (kind < 55) begin
			plan_request(a, f, n, 0, 0, 0);
		end else if (kind < 65) begin
			plan_request(a, f, n, 1, 0, 0);
		end else if (kind < 72) begin
			do a = 8'($urandom_range(0, 255)); while (a == sb.station_addr);
			plan_request(a, f, n, 0, 0, $urandom_range(0, 3));
		end else if (kind < 80) begin
			do f = 8'($urandom_range(0, 255));
			while ((f >= mrfc_pkg::FC_FIXED_LO && f <= mrfc_pkg::FC_FIXED_HI) ||
				f == mrfc_pkg::FC_WR_COILS || f == mrfc_pkg::FC_WR_REGS);
			plan_request(a, f, n, 0, 0, 0);
		end else if (kind < 88) begin
			// A frame cut short; the next frame start interrupts it.
			plan_request(a, f, n, $urandom_range(0, 1), $urandom_range(1, 7), 0);
		end else if (kind < 94) begin
			// Bytes past the expected length are still counted.
			plan_request(a, f, n, 0, 0, $urandom_range(1, 4));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
		end
	endtask

	// Offers one beat from the falling edge on, after any random idle
	// cycles, and returns at the rising edge where it is taken.
	task automatic send_beat(input rx_beat_t x);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = x.data;
		s_tuser  = x.start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_plan();
		while (plan_q.size() != 0) begin
			send_beat(plan_q.pop_front());
		end
	endtask

	// Stops offering and waits until every predicted beat has arrived, then
	// waits out the block's pipeline.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.status_due_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes the slave address register while nothing is in flight.
	task automatic write_station_address(input logic [7:0] a);
		drain_results();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = a;
		sb.set_station(a);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int         ph;
		int         k;
		int         first_bytes;
		bit         mid_done;
		logic [7:0] phase_addr [6];
		logic [7:0] next_addr;

		sb           = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 8'h00;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tuser      = 1'b0;
		m_tready     = 1'b0;
		tx_idle_pct  = 19;
		rx_idle_pct  = 87;
		hold_request = 0;
		hold_left    = 0;

		// The extremes 0 and 255, the reset value, and random addresses.
		phase_addr[0] = 8'h00;
		phase_addr[1] = 8'hFF;
		phase_addr[2] = 8'($urandom_range(0, 255));
		phase_addr[3] = 8'($urandom_range(0, 255));
		phase_addr[4] = mrfc_pkg::SLAVE_ADDR_RESET;
		phase_addr[5] = 8'($urandom_range(0, 255));

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, with the reset slave address. Bytes before any frame
		// start are dropped; then a fixed-length frame, a write-multiple frame
		// with no data, a wrong address and a wrong function.
		add_beat(8'h00, 1'b0);
		add_beat(8'hFF, 1'b0);
		plan_request(mrfc_pkg::SLAVE_ADDR_RESET, mrfc_pkg::FC_FIXED_HI, 0, 0, 0, 0);
		plan_request(mrfc_pkg::SLAVE_ADDR_RESET, mrfc_pkg::FC_WR_COILS, 0, 0, 0, 0);
		plan_request(8'hFF, mrfc_pkg::FC_FIXED_LO + 8'd2, 0, 0, 5, 0);
		plan_request(mrfc_pkg::SLAVE_ADDR_RESET, 8'h00, 0, 0, 5, 0);
		send_plan();

		// Random phases. The first two leave the sender mostly busy and the
		// receiver mostly idle, the next two swap that, the last two idle on
		// neither side.
		for (ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				tx_idle_pct = 19;
				rx_idle_pct = 87;
			end else if (ph < 4) begin
				tx_idle_pct = 87;
				rx_idle_pct = 19;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			next_addr = phase_addr[ph];

			// A request for the coming address is split around the register
			// write, so the address check at byte five sees the new value.
			plan_request(next_addr, pick_served_func(), $urandom_range(0, 6), 0, 0, 0);
			for (k = 0; k < 3; k++) begin
				send_beat(plan_q.pop_front());
			end
			write_station_address(next_addr);
			send_plan();

			if (ph == 5) begin
				// One long write-multiple frame followed by plain bytes runs
				// the byte counter into saturation.
				plan_request(next_addr, mrfc_pkg::FC_WR_REGS, 255, 0, 0, 260);
				send_plan();
			end

			first_bytes = sb.bytes_framed;
			mid_done    = 0;
			while (sb.bytes_framed - first_bytes < PHASE_BYTES) begin
				if (!mid_done && sb.bytes_framed - first_bytes >= PHASE_BYTES / 2) begin
					mid_done = 1;
					if (ph == 4) begin
						// The receiver holds off while bytes keep coming, so
						// the block fills and stalls its input.
						hold_request = HOLD_CYCLES;
					end else begin
						drain_results();
					end
				end
				plan_random_traffic();
				send_plan();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);

		$display("Checked %0d status beats over %0d framed bytes: %0d complete frames,",
			sb.beats_checked, sb.bytes_framed, sb.frames_complete);
		$display("%0d with a good CRC, %0d address and %0d function rejections.",
			sb.frames_crc_good, sb.addr_rejects, sb.func_rejects);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
